[rtl/core/ccc_pkg.sv]
package ccc_pkg;

    // Charge mode, also the encoding of the mode output field
    typedef enum logic [1:0] {
        MODE_CHARGE  = 2'd0,
        MODE_CV      = 2'd1,
        MODE_MEASURE = 2'd2,
        MODE_RESET   = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam logic [2:0] CFG_EIS_DONE   = 3'd0;
    localparam logic [2:0] CFG_CV_ENTRY   = 3'd1;
    localparam logic [2:0] CFG_END_CUR    = 3'd2;
    localparam logic [2:0] CFG_COUNT_CUR  = 3'd3;

    localparam logic               EIS_DONE_RST  = 1'b1;
    localparam logic signed [15:0] CV_ENTRY_RST  = 16'sd3530;
    localparam logic signed [15:0] END_CUR_RST   = 16'sd97;
    localparam logic signed [15:0] COUNT_CUR_RST = 16'sd100;

    // One capacity block: 712 mAh worth of 1 s samples
    localparam logic [22:0] BLOCK_UNITS = 23'd2563200;
    localparam logic [15:0] BLOCKS_MAX  = 16'hFFFF;
    localparam logic [15:0] TICK_MAX    = 16'hFFFF;

    // accum * 65536 / 2563200 == (accum << 9) / 20025
    localparam int          FRAC_SHIFT  = 9;
    localparam logic [14:0] DIV_ODD     = 15'd20025;
    // floor(2^39 / 20025); the quotient estimate is low by at most one
    localparam int          RECIP_SHIFT = 30;
    localparam logic [63:0] RECIP_FULL  = (64'd1 << 39) / 64'd20025;
    localparam logic [24:0] RECIP       = RECIP_FULL[24:0];

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic signed [15:0] current_sample;
        logic signed [15:0] voltage_sample;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  mode;
        logic        cc_relay;
        logic        cv_relay;
        logic        eis_relay;
        logic        red_led;
        logic        green_led;
        logic [31:0] capacity;
        logic [15:0] reset_ticks;
    } t_out_req;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    // Classified tick handed from front to back
    typedef struct packed {
        t_mode       mode;
        logic [15:0] ticks;
        logic        cap_req;
        logic [22:0] accum;
        logic [15:0] blocks;
    } t_job;

endpackage

[rtl/core/ccc_front.sv]
module ccc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  ccc_pkg::t_cfg_wr i_cfg,
    input  logic            i_accept,
    input  ccc_pkg::t_in_req i_req,
    output ccc_pkg::t_job   o_job
);

    logic               r_eis_done;
    logic signed [15:0] r_cv_entry;
    logic signed [15:0] r_end_cur;
    logic signed [15:0] r_count_cur;

    logic [22:0]    r_accum, n_accum;
    logic [15:0]    r_blocks, n_blocks;
    logic           r_cv_latch, n_cv_latch;
    logic           r_cc_latch, n_cc_latch;
    logic           r_done_latch, n_done_latch;
    ccc_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_ticks, n_ticks;
    logic           n_cap_req;

    logic signed [24:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eis_done  <= ccc_pkg::EIS_DONE_RST;
            r_cv_entry  <= ccc_pkg::CV_ENTRY_RST;
            r_end_cur   <= ccc_pkg::END_CUR_RST;
            r_count_cur <= ccc_pkg::COUNT_CUR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg.index)
                ccc_pkg::CFG_EIS_DONE:  r_eis_done  <= i_cfg.data[0];
                ccc_pkg::CFG_CV_ENTRY:  r_cv_entry  <= i_cfg.data;
                ccc_pkg::CFG_END_CUR:   r_end_cur   <= i_cfg.data;
                ccc_pkg::CFG_COUNT_CUR: r_count_cur <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum      <= '0;
            r_blocks     <= '0;
            r_cv_latch   <= 1'b0;
            r_cc_latch   <= 1'b1;
            r_done_latch <= 1'b0;
            r_mode       <= ccc_pkg::MODE_RESET;
            r_ticks      <= '0;
        end else if (i_accept) begin
            r_accum      <= n_accum;
            r_blocks     <= n_blocks;
            r_cv_latch   <= n_cv_latch;
            r_cc_latch   <= n_cc_latch;
            r_done_latch <= n_done_latch;
            r_mode       <= n_mode;
            r_ticks      <= n_ticks;
        end
    end

    always_comb begin
        n_accum      = r_accum;
        n_blocks     = r_blocks;
        n_cv_latch   = r_cv_latch;
        n_cc_latch   = r_cc_latch;
        n_done_latch = r_done_latch;
        n_mode       = r_mode;
        n_ticks      = r_ticks;
        n_cap_req    = 1'b0;
        sum = $signed({2'b00, r_accum}) + $signed({{9{i_req.current_sample[15]}},
                                                   i_req.current_sample});

        // coulomb counter
        if (i_req.current_sample > r_count_cur) begin
            if (r_accum > ccc_pkg::BLOCK_UNITS) begin
                if (r_blocks != ccc_pkg::BLOCKS_MAX) begin
                    n_blocks = r_blocks + 16'd1;
                end
                n_accum = r_accum - ccc_pkg::BLOCK_UNITS;
            end else if (sum[24]) begin
                n_accum = '0;
            end else begin
                n_accum = sum[22:0];
            end
        end

        // mode control
        if (!r_eis_done) begin
            n_mode = ccc_pkg::MODE_MEASURE;
        end else if (r_done_latch) begin
            n_mode    = ccc_pkg::MODE_RESET;
            n_cap_req = 1'b1;
            if (r_ticks != ccc_pkg::TICK_MAX) begin
                n_ticks = r_ticks + 16'd1;
            end
        end else if (i_req.voltage_sample > r_cv_entry || r_cv_latch) begin
            if (i_req.current_sample < r_end_cur) begin
                n_cv_latch   = 1'b0;
                n_cc_latch   = 1'b1;
                n_done_latch = 1'b1;
                n_mode       = ccc_pkg::MODE_RESET;
            end else begin
                n_cv_latch = 1'b1;
                n_cc_latch = 1'b0;
                n_mode     = ccc_pkg::MODE_CV;
            end
        end else if (r_cc_latch) begin
            n_mode = ccc_pkg::MODE_CHARGE;
        end

        o_job.mode    = n_mode;
        o_job.ticks   = n_ticks;
        o_job.cap_req = n_cap_req;
        o_job.accum   = n_accum;
        o_job.blocks  = n_blocks;
    end

endmodule

[rtl/core/ccc_queue.sv]
module ccc_queue #(
    parameter int QUEUE_DEPTH = ccc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ccc_pkg::t_job i_job,
    input  logic          i_pop,
    output ccc_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    ccc_pkg::t_job r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/ccc_back.sv]
module ccc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccc_pkg::t_job     i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output ccc_pkg::t_out_req o_data
);

    // s1: reciprocal product, s2: remainder product, s3: corrected quotient,
    // s4: capacity sum, capture and output register
    logic          en;
    logic          r_v1, r_v2, r_v3, r_v4;
    ccc_pkg::t_job r_j1, r_j2, r_j3;
    logic [47:0]   r_prod1;
    logic [17:0]   r_q0;
    logic [32:0]   r_prod2;
    logic [17:0]   r_q;
    logic [31:0]   r_captured;
    ccc_pkg::t_out_req r_out;

    logic [17:0] q0;
    logic [32:0] num, rem;
    logic [32:0] total;
    logic [31:0] cap_val, n_captured;

    assign en      = !(r_v4 && i_stall);
    assign o_pop   = en && !i_empty;
    assign o_valid = r_v4;
    assign o_data  = r_out;

    assign q0    = r_prod1[ccc_pkg::RECIP_SHIFT +: 18];
    assign num   = {1'b0, r_j2.accum, {ccc_pkg::FRAC_SHIFT{1'b0}}};
    assign rem   = num - r_prod2;
    assign total = {1'b0, r_j3.blocks, 16'd0} + {15'd0, r_q};
    assign cap_val = total[32] ? 32'hFFFF_FFFF : total[31:0];

    always_comb begin
        n_captured = r_captured;
        if (r_j3.cap_req && r_captured == '0) begin
            n_captured = cap_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_captured <= '0;
        end else if (en) begin
            r_v1 <= !i_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_v3) begin
                r_captured <= n_captured;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j1    <= i_job;
            r_prod1 <= {25'd0, i_job.accum} * {23'd0, ccc_pkg::RECIP};
            r_j2    <= r_j1;
            r_q0    <= q0;
            r_prod2 <= {15'd0, q0} * {18'd0, ccc_pkg::DIV_ODD};
            r_j3    <= r_j2;
            r_q     <= (rem >= {18'd0, ccc_pkg::DIV_ODD}) ? r_q0 + 18'd1 : r_q0;
            r_out.mode        <= r_j3.mode;
            r_out.cc_relay    <= (r_j3.mode == ccc_pkg::MODE_CHARGE);
            r_out.cv_relay    <= (r_j3.mode == ccc_pkg::MODE_CV);
            r_out.eis_relay   <= (r_j3.mode == ccc_pkg::MODE_MEASURE);
            r_out.red_led     <= (r_j3.mode == ccc_pkg::MODE_CV ||
                                  r_j3.mode == ccc_pkg::MODE_RESET);
            r_out.green_led   <= (r_j3.mode == ccc_pkg::MODE_CHARGE ||
                                  r_j3.mode == ccc_pkg::MODE_RESET);
            r_out.capacity    <= n_captured;
            r_out.reset_ticks <= r_j3.ticks;
        end
    end

endmodule

[rtl/core/cc_cv_charge_controller_top.sv]
// Channel   Direction  Handshake            Payload
// in        request    i_in_valid/o_in_stall  ccc_pkg::t_in_req  (current, voltage)
// out       result     o_out_valid/i_out_stall ccc_pkg::t_out_req (mode, drives, counters)
// cfg       write      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle while the queue is not full; a request passes through the front
// update into the queue, then the 4-stage capacity pipeline in the back.
// The front keeps mode and charge state across ticks; the back holds the captured
// capacity and converts the charge accumulator to Q16.16: reciprocal multiply, one fixup.
// Synchronous active-low reset; no clearing pass. o_cfg_ready is always high.
// A stall with a result held freezes the back; the queue absorbs requests until full.
module cc_cv_charge_controller_top #(
    parameter int QUEUE_DEPTH = ccc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ccc_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ccc_pkg::t_out_req o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    ccc_pkg::t_cfg_wr cfg;
    ccc_pkg::t_job    front_job, head_job;
    logic             accept, pop, q_empty, q_full;

    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;
    assign o_cfg_ready = 1'b1;

    // stall only while the queue is full
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    ccc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_req       (i_in_data),
        .o_job       (front_job)
    );

    ccc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ccc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
